// ----- hw/rtl/fpad_pkg.sv -----
// ----------------------------------------------------------------------------
// fpad_pkg
// Shared types, register indexes and helpers for the page address splitter.
// ----------------------------------------------------------------------------
package fpad_pkg;

  localparam int NUMBER_WIDTH_DEF = 48;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 17;
  localparam int RADIX_W          = 7;   // per-digit radix, up to 64
  localparam int WIDE_RADIX_W     = 17;  // block and page radix, up to 65536
  localparam int PROD_W           = 36;  // product of all counts but pages
  localparam int ALIGNED_W        = 48;
  localparam int NEXT_W           = 49;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL = 3'd0,
    REG_WAY     = 3'd1,
    REG_DIE     = 3'd2,
    REG_PLANE   = 3'd3,
    REG_BLOCK   = 3'd4,
    REG_PAGE    = 3'd5,
    REG_ORDER   = 3'd6
  } fpad_reg_t;

  typedef enum logic [1:0] {
    CODE_CHANNEL = 2'd0,
    CODE_WAY     = 2'd1,
    CODE_DIE     = 2'd2,
    CODE_PLANE   = 2'd3
  } fpad_code_t;

  typedef struct packed {
    logic [5:0]  channel;
    logic [5:0]  way;
    logic [3:0]  die;
    logic [2:0]  plane;
    logic [15:0] block;
    logic [15:0] page;
  } fpad_dig_t;

  // zero acts as one, anything above the bound acts as the bound
  function automatic logic [16:0] fpad_clamp(input logic [16:0] v, input logic [16:0] hi);
    logic [16:0] r;
    r = v;
    if (v == 17'd0) r = 17'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // later positions overwrite earlier ones
  function automatic fpad_dig_t fpad_set_digit(input fpad_dig_t d, input fpad_code_t c,
                                               input logic [5:0] v);
    fpad_dig_t r;
    r = d;
    case (c)
      CODE_CHANNEL: r.channel = v;
      CODE_WAY:     r.way     = v;
      CODE_DIE:     r.die     = v[3:0];
      CODE_PLANE:   r.plane   = v[2:0];
      default:      r = d;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/fpad_div.sv -----
// ----------------------------------------------------------------------------
// fpad_div
// Pipelined restoring divider: BPS quotient bits per stage, side data
// travels alongside.
// ----------------------------------------------------------------------------
module fpad_div #(
  parameter int W   = 48,
  parameter int DW  = 7,
  parameter int BPS = 4,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [W-1:0]  in_num,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [W-1:0]  out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int STAGES = (W + BPS - 1) / BPS;
  localparam int WP     = STAGES * BPS;

  logic          vld_r  [STAGES];
  logic [DW-1:0] rem_r  [STAGES];
  logic [WP-1:0] q_r    [STAGES];
  logic [SW-1:0] side_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in, rem_nxt;
    logic [WP-1:0] q_in, q_nxt;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign q_in    = WP'(in_num);
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign q_in    = q_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_nxt = rem_in;
      q_nxt   = q_in;
      t       = '0;
      for (int b = 0; b < BPS; b++) begin
        t     = {rem_nxt, q_nxt[WP-1]};
        q_nxt = {q_nxt[WP-2:0], 1'b0};
        if (t >= {1'b0, divisor}) begin
          t        = t - {1'b0, divisor};
          q_nxt[0] = 1'b1;
        end
        rem_nxt = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_quo  = q_r[STAGES-1][W-1:0];
  assign out_rem  = rem_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

// ----- hw/rtl/fpad_product.sv -----
// ----------------------------------------------------------------------------
// fpad_product
// Product of channel, way, die, plane and block counts, three register steps.
// ----------------------------------------------------------------------------
module fpad_product (
  input  logic                            clk,
  input  logic [fpad_pkg::RADIX_W-1:0]    r_channel,
  input  logic [fpad_pkg::RADIX_W-1:0]    r_way,
  input  logic [fpad_pkg::RADIX_W-1:0]    r_die,
  input  logic [fpad_pkg::RADIX_W-1:0]    r_plane,
  input  logic [fpad_pkg::WIDE_RADIX_W-1:0] r_block,
  output logic [fpad_pkg::PROD_W-1:0]     product
);
  import fpad_pkg::*;

  logic [13:0]       cw_r;
  logic [13:0]       dp_r;
  logic [27:0]       cwdp_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    cw_r   <= r_channel * r_way;
    dp_r   <= r_die * r_plane;
    cwdp_r <= cw_r * dp_r;
    // 20 x 17 bits, formed at the full product width
    prod_r <= cwdp_r[19:0] * r_block;
  end

  assign product = prod_r;

endmodule

// ----- hw/rtl/flash_page_address_decompose.sv -----
// ----------------------------------------------------------------------------
// flash_page_address_decompose
// Splits a physical page number into channel/way/die/plane/block/page digits.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall carry one request: a page number. out_valid/out_stall
//    return one result per request, in order: six digits, the number modulo
//    the count product and the next page number.
//  - cfg_we/cfg_index/cfg_data write the count and order registers; write
//    only while no request is in flight.
//  - Four chained dividers peel off the low digits in allocation order, two
//    more give block and page, and a final one forms the remainder modulo
//    the count product (multiplied up from the registers in fpad_product).
//  - Throughput: one request per cycle while no result is held by out_stall;
//    every divider stage is registered.
//  - Reset clears all valid bits and loads the register defaults.
//  - A stall on a valid output freezes the whole pipe and asserts in_stall;
//    nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module flash_page_address_decompose #(
  parameter int NUMBER_WIDTH = fpad_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpad_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [NUMBER_WIDTH-1:0]         in_page_number,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [5:0]                      out_channel_index,
  output logic [5:0]                      out_way_index,
  output logic [3:0]                      out_die_index,
  output logic [2:0]                      out_plane_index,
  output logic [15:0]                     out_block_index,
  output logic [15:0]                     out_page_index,
  output logic [fpad_pkg::ALIGNED_W-1:0]  out_aligned_number,
  output logic [fpad_pkg::NEXT_W-1:0]     out_next_page_number
);
  import fpad_pkg::*;

  localparam int NW   = NUMBER_WIDTH;
  localparam int DGW  = $bits(fpad_dig_t);
  localparam int SW   = NW + DGW;
  localparam int SUMW = ((NW > PROD_W) ? NW : PROD_W) + 1;

  // configuration registers
  logic [6:0]  channel_cnt_r, way_cnt_r;
  logic [4:0]  die_cnt_r;
  logic [3:0]  plane_cnt_r;
  logic [16:0] block_cnt_r, page_cnt_r;
  logic [7:0]  order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_cnt_r <= 7'd8;
      way_cnt_r     <= 7'd4;
      die_cnt_r     <= 5'd1;
      plane_cnt_r   <= 4'd1;
      block_cnt_r   <= 17'd1024;
      page_cnt_r    <= 17'd256;
      order_r       <= 8'd228;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL: channel_cnt_r <= cfg_data[6:0];
        REG_WAY:     way_cnt_r     <= cfg_data[6:0];
        REG_DIE:     die_cnt_r     <= cfg_data[4:0];
        REG_PLANE:   plane_cnt_r   <= cfg_data[3:0];
        REG_BLOCK:   block_cnt_r   <= cfg_data;
        REG_PAGE:    page_cnt_r    <= cfg_data;
        REG_ORDER:   order_r       <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // effective radices
  logic [RADIX_W-1:0]      radix [4];
  logic [WIDE_RADIX_W-1:0] r_block, r_page;
  logic [PROD_W-1:0]       product;

  assign radix[0] = RADIX_W'(fpad_clamp(17'(channel_cnt_r), 17'd64));
  assign radix[1] = RADIX_W'(fpad_clamp(17'(way_cnt_r), 17'd64));
  assign radix[2] = RADIX_W'(fpad_clamp(17'(die_cnt_r), 17'd16));
  assign radix[3] = RADIX_W'(fpad_clamp(17'(plane_cnt_r), 17'd8));
  assign r_block  = fpad_clamp(block_cnt_r, 17'd65536);
  assign r_page   = fpad_clamp(page_cnt_r, 17'd65536);

  fpad_product u_product (
    .clk       (clk),
    .r_channel (radix[0]),
    .r_way     (radix[1]),
    .r_die     (radix[2]),
    .r_plane   (radix[3]),
    .r_block   (r_block),
    .product   (product)
  );

  // whole pipe moves unless a result is held by the receiver
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // chain of four low-digit dividers, side data = {page number, digits}
  logic          vld_c  [5];
  logic [NW-1:0] q_c    [5];
  logic [SW-1:0] side_c [5];

  assign vld_c[0]  = in_valid;
  assign q_c[0]    = in_page_number;
  assign side_c[0] = {in_page_number, DGW'(0)};

  for (genvar i = 0; i < 4; i++) begin : g_digit
    fpad_code_t         code;
    logic               vld_o;
    logic [NW-1:0]      quo_o;
    logic [RADIX_W-1:0] rem_o;
    logic [SW-1:0]      side_o;
    fpad_dig_t          dig;

    assign code = fpad_code_t'(order_r[2*i +: 2]);

    fpad_div #(.W(NW), .DW(RADIX_W), .BPS(4), .SW(SW)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld_c[i]),
      .in_num   (q_c[i]),
      .divisor  (radix[code]),
      .in_side  (side_c[i]),
      .out_vld  (vld_o),
      .out_quo  (quo_o),
      .out_rem  (rem_o),
      .out_side (side_o)
    );

    assign dig        = fpad_set_digit(fpad_dig_t'(side_o[DGW-1:0]), code, rem_o[5:0]);
    assign vld_c[i+1] = vld_o;
    assign q_c[i+1]   = quo_o;
    assign side_c[i+1] = {side_o[SW-1:DGW], dig};
  end

  // block digit
  logic                    blk_vld;
  logic [NW-1:0]           blk_quo;
  logic [WIDE_RADIX_W-1:0] blk_rem;
  logic [SW-1:0]           blk_side;
  fpad_dig_t               blk_dig;

  fpad_div #(.W(NW), .DW(WIDE_RADIX_W), .BPS(4), .SW(SW)) u_div_block (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld_c[4]),
    .in_num   (q_c[4]),
    .divisor  (r_block),
    .in_side  (side_c[4]),
    .out_vld  (blk_vld),
    .out_quo  (blk_quo),
    .out_rem  (blk_rem),
    .out_side (blk_side)
  );

  always_comb begin
    blk_dig       = fpad_dig_t'(blk_side[DGW-1:0]);
    blk_dig.block = blk_rem[15:0];
  end

  // page digit, quotient not needed
  logic                    pg_vld;
  logic [WIDE_RADIX_W-1:0] pg_rem;
  logic [SW-1:0]           pg_side;
  fpad_dig_t               pg_dig;

  fpad_div #(.W(NW), .DW(WIDE_RADIX_W), .BPS(4), .SW(SW)) u_div_page (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (blk_vld),
    .in_num   (blk_quo),
    .divisor  (r_page),
    .in_side  ({blk_side[SW-1:DGW], blk_dig}),
    .out_vld  (pg_vld),
    .out_quo  (),
    .out_rem  (pg_rem),
    .out_side (pg_side)
  );

  always_comb begin
    pg_dig      = fpad_dig_t'(pg_side[DGW-1:0]);
    pg_dig.page = pg_rem[15:0];
  end

  // remainder modulo the count product; page number rides along as side data
  logic              al_vld;
  logic [PROD_W-1:0] al_rem;
  logic [SW-1:0]     al_side;
  logic [SUMW-1:0]   next_sum;

  fpad_div #(.W(NW), .DW(PROD_W), .BPS(2), .SW(SW)) u_div_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (pg_vld),
    .in_num   (pg_side[SW-1:DGW]),
    .divisor  (product),
    .in_side  ({pg_side[SW-1:DGW], pg_dig}),
    .out_vld  (al_vld),
    .out_quo  (),
    .out_rem  (al_rem),
    .out_side (al_side)
  );

  assign next_sum = SUMW'(al_side[SW-1:DGW]) + SUMW'(product);

  // output register
  fpad_dig_t              out_dig_r;
  logic [ALIGNED_W-1:0]   aligned_r;
  logic [NEXT_W-1:0]      next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= al_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dig_r <= fpad_dig_t'(al_side[DGW-1:0]);
      aligned_r <= ALIGNED_W'(al_rem);
      next_r    <= NEXT_W'(next_sum);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_index    = out_dig_r.channel;
  assign out_way_index        = out_dig_r.way;
  assign out_die_index        = out_dig_r.die;
  assign out_plane_index      = out_dig_r.plane;
  assign out_block_index      = out_dig_r.block;
  assign out_page_index       = out_dig_r.page;
  assign out_aligned_number   = aligned_r;
  assign out_next_page_number = next_r;

endmodule

// ----- hw/rtl/fpad_checker.sv -----
// ----------------------------------------------------------------------------
// fpad_checker
// Port-level checks for the page address splitter, bound to the top level.
// ----------------------------------------------------------------------------
module fpad_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [fpad_pkg::ALIGNED_W-1:0] out_aligned_number,
  input logic [fpad_pkg::NEXT_W-1:0]    out_next_page_number
);
  import fpad_pkg::*;

  // input held off only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // held result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // next page lies beyond the aligned number
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_next_page_number > NEXT_W'(out_aligned_number)))
    else $error("next page not above aligned number");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind flash_page_address_decompose fpad_checker u_fpad_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_aligned_number   (out_aligned_number),
  .out_next_page_number (out_next_page_number)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flash page address splitter. It drives page
// numbers over several count/order settings and varies idling on both sides.
// Each result is compared field by field against an in-bench mixed-radix
// decomposition.
// ----------------------------------------------------------------------------
module tb;
  import fpad_pkg::*;

  localparam int NW        = 48;
  localparam int DRAIN     = 110;   // more than the 97 pipe stages
  localparam int STALL_MAX = 2000;  // cycles without any transfer

  typedef struct packed {
    logic [5:0]  channel;
    logic [5:0]  way;
    logic [3:0]  die;
    logic [2:0]  plane;
    logic [15:0] block;
    logic [15:0] page;
    logic [47:0] aligned;
    logic [48:0] next;
  } addr_fields_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [16:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [NW-1:0] in_page_number = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [5:0]    out_channel_index, out_way_index;
  logic [3:0]    out_die_index;
  logic [2:0]    out_plane_index;
  logic [15:0]   out_block_index, out_page_index;
  logic [47:0]   out_aligned_number;
  logic [48:0]   out_next_page_number;

  // bench copy of the registers, masked to the register widths
  logic [16:0]   shadow [0:6];
  logic [NW-1:0] page_queue [$];
  addr_fields_t  expected_fields [$];
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  logic          hold_off = 1'b0;
  int            errors = 0;
  int            quiet_cycles = 0;

  flash_page_address_decompose #(.NUMBER_WIDTH(NW)) dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // zero acts as one, anything above the bound as the bound
  function automatic longint unsigned eff_count(fpad_reg_t r);
    longint unsigned v, hi;
    v = shadow[r];
    case (r)
      REG_CHANNEL, REG_WAY: hi = 64;
      REG_DIE:              hi = 16;
      REG_PLANE:            hi = 8;
      default:              hi = 65536;
    endcase
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned low_product();
    return eff_count(REG_CHANNEL) * eff_count(REG_WAY) * eff_count(REG_DIE) *
           eff_count(REG_PLANE) * eff_count(REG_BLOCK);
  endfunction

  function automatic addr_fields_t decompose(logic [NW-1:0] pn);
    addr_fields_t    f;
    longint unsigned q, r, prod;
    longint unsigned dig [0:3];
    fpad_code_t      code;
    f = '0;
    q = 64'(pn);
    for (int i = 0; i < 4; i++) dig[i] = 0;
    // low digits in allocation order; a repeated code divides again and
    // keeps the value from its most significant position
    for (int i = 0; i < 4; i++) begin
      code = fpad_code_t'(shadow[REG_ORDER][2*i +: 2]);
      case (code)
        CODE_CHANNEL: r = eff_count(REG_CHANNEL);
        CODE_WAY:     r = eff_count(REG_WAY);
        CODE_DIE:     r = eff_count(REG_DIE);
        default:      r = eff_count(REG_PLANE);
      endcase
      dig[code] = q % r;
      q = q / r;
    end
    f.channel = 6'(dig[CODE_CHANNEL]);
    f.way     = 6'(dig[CODE_WAY]);
    f.die     = 4'(dig[CODE_DIE]);
    f.plane   = 3'(dig[CODE_PLANE]);
    f.block   = 16'(q % eff_count(REG_BLOCK));
    q         = q / eff_count(REG_BLOCK);
    f.page    = 16'(q % eff_count(REG_PAGE));
    prod      = low_product();
    f.aligned = 48'(64'(pn) % prod);
    f.next    = 49'(64'(pn) + prod);
    return f;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $time);
    errors++;
  endtask

  // request driver: payload held while stalled
  always @(posedge clk) begin
    logic busy;
    busy = in_valid;
    if (rst_n && in_valid && !in_stall) begin
      expected_fields.push_back(decompose(in_page_number));
      void'(page_queue.pop_front());
      busy = 1'b0;
    end
    if (!busy) begin
      if (rst_n && page_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_page_number <= page_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    addr_fields_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fields.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = expected_fields.pop_front();
        if (out_channel_index !== w.channel) report("channel", out_channel_index, w.channel);
        if (out_way_index !== w.way)         report("way", out_way_index, w.way);
        if (out_die_index !== w.die)         report("die", out_die_index, w.die);
        if (out_plane_index !== w.plane)     report("plane", out_plane_index, w.plane);
        if (out_block_index !== w.block)     report("block", out_block_index, w.block);
        if (out_page_index !== w.page)       report("page", out_page_index, w.page);
        if (out_aligned_number !== w.aligned)
          report("aligned", out_aligned_number, w.aligned);
        if (out_next_page_number !== w.next)
          report("next", out_next_page_number, w.next);
      end
    end
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // watchdog on transfers in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("flash_page_address_decompose regression: fail");
      $finish;
    end
  end

  task automatic write_reg(fpad_reg_t r, logic [16:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_CHANNEL, REG_WAY: shadow[r] = v & 17'h7F;
      REG_DIE:              shadow[r] = v & 17'h1F;
      REG_PLANE:            shadow[r] = v & 17'hF;
      REG_ORDER:            shadow[r] = v & 17'hFF;
      default:              shadow[r] = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_counts(logic [16:0] ch, logic [16:0] wy, logic [16:0] di,
                            logic [16:0] pl, logic [16:0] bk, logic [16:0] pg,
                            logic [16:0] ord);
    write_reg(REG_CHANNEL, ch);
    write_reg(REG_WAY, wy);
    write_reg(REG_DIE, di);
    write_reg(REG_PLANE, pl);
    write_reg(REG_BLOCK, bk);
    write_reg(REG_PAGE, pg);
    write_reg(REG_ORDER, ord);
  endtask

  // mostly full-width values, plus small ones and values around multiples
  // of the low-digit product where the carries into block and page happen
  task automatic queue_random(int n);
    logic [63:0]     v;
    longint unsigned prod;
    prod = low_product();
    repeat (n) begin
      case ($urandom_range(3))
        0, 1: v = {$urandom, $urandom};
        2:    v = 64'($urandom_range(4095));
        default: v = prod * 64'($urandom_range(70000)) + 64'($urandom_range(2)) - 64'd1;
      endcase
      page_queue.push_back(v[NW-1:0]);
    end
  endtask

  task automatic drain();
    while (page_queue.size() > 0 || in_valid || expected_fields.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 62; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 62; end
      default: begin send_idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  initial begin
    logic [63:0] p;
    shadow[REG_CHANNEL] = 8;
    shadow[REG_WAY]     = 4;
    shadow[REG_DIE]     = 1;
    shadow[REG_PLANE]   = 1;
    shadow[REG_BLOCK]   = 1024;
    shadow[REG_PAGE]    = 256;
    shadow[REG_ORDER]   = 228;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes and digit boundaries
    p = low_product();
    page_queue.push_back('0);
    page_queue.push_back({NW{1'b1}});
    page_queue.push_back(48'h5555_5555_5555);
    page_queue.push_back(48'hAAAA_AAAA_AAAA);
    page_queue.push_back(NW'(1));
    page_queue.push_back(NW'(7));
    page_queue.push_back(NW'(8));
    page_queue.push_back(NW'(31));
    page_queue.push_back(NW'(32));
    page_queue.push_back(NW'(p - 64'd1));
    page_queue.push_back(NW'(p));
    page_queue.push_back(NW'(p * 64'd255 + p - 64'd1));
    page_queue.push_back(NW'(p * 64'd256));
    page_queue.push_back(NW'(p * 64'd257 + 64'd5));
    page_queue.push_back(48'h8000_0000_0000);
    drain();

    // full bounds, reversed order
    set_idling(1);
    set_counts(64, 64, 16, 8, 17'h10000, 17'h10000, 8'h1B);
    page_queue.push_back({NW{1'b1}});
    page_queue.push_back(48'h7_FFFF_FFFF);
    page_queue.push_back(48'h8_0000_0000);
    queue_random(50);
    drain();

    // every radix one: all digits zero
    set_idling(2);
    set_counts(1, 1, 1, 1, 1, 1, 8'hE4);
    queue_random(50);
    drain();

    // zero counts act as one; order repeats the channel code
    set_idling(3);
    set_counts(0, 5, 0, 3, 0, 7, 8'h00);
    queue_random(50);
    drain();

    // counts above their bound; order repeats the plane code
    set_idling(0);
    set_counts(127, 127, 31, 15, 17'h1FFFF, 17'h1FFFF, 8'hFF);
    queue_random(55);
    drain();

    set_idling(1);
    set_counts(3, 5, 7, 6, 1000, 33, 8'h4E);
    queue_random(50);
    drain();

    set_idling(2);
    set_counts(17'($urandom_range(64)), 17'($urandom_range(64)), 17'($urandom_range(16)),
               17'($urandom_range(8)), 17'($urandom_range(65536)),
               17'($urandom_range(65536)), 17'($urandom_range(255)));
    queue_random(50);
    drain();

    // long receiver hold-off while requests keep coming: pipe fills up
    set_idling(0);
    set_counts(7, 1, 2, 8, 65535, 3, 8'hB1);
    queue_random(130);
    @(posedge clk);
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    drain();

    if (errors == 0 && expected_fields.size() == 0) begin
      $display("flash_page_address_decompose regression: pass");
    end else begin
      $display("flash_page_address_decompose regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/fpad_pkg.sv
hw/rtl/fpad_div.sv
hw/rtl/fpad_product.sv
hw/rtl/flash_page_address_decompose.sv
hw/rtl/fpad_checker.sv
dv/tb.sv
